@@ hdl/pud_pkg.sv @@
`timescale 1ns / 1ps

package pud_pkg;

	localparam logic [7:0] PCT_CHAR   = 8'h25;
	localparam logic [7:0] PLUS_CHAR  = 8'h2B;
	localparam logic [7:0] SPACE_CHAR = 8'h20;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned BURST_MAX   = 3;

	typedef enum logic [1:0] {
		HELD_NONE  = 2'd0,
		HELD_PCT   = 2'd1,
		HELD_DIGIT = 2'd2
	} held_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} entry_t;

	// up to three bytes produced by one input item
	typedef struct packed {
		logic [1:0] num;
		entry_t [BURST_MAX-1:0] slot;
	} burst_t;

	// {valid, nibble}
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end
		return r;
	endfunction

endpackage

@@ hdl/pud_decode.sv @@
`timescale 1ns / 1ps

module pud_decode (
	input  logic [7:0]      in_byte,
	input  logic            in_last,
	input  logic            plus_to_space,
	input  pud_pkg::held_t  held,
	input  logic [7:0]      held_digit,
	output pud_pkg::held_t  held_next,
	output pud_pkg::burst_t burst
);
	import pud_pkg::*;

	logic [4:0] hv_in;
	logic [4:0] hv_held;
	logic [7:0] raw [BURST_MAX];
	logic [1:0] n;
	held_t      hn;
	logic [7:0] tail_digit;

	assign hv_in   = hex_decode(in_byte);
	assign hv_held = hex_decode(held_digit);

	always_comb begin
		for (int i = 0; i < BURST_MAX; i++) begin
			raw[i] = PCT_CHAR;
		end
		n          = 2'd0;
		hn         = HELD_NONE;
		tail_digit = held_digit;

		case (held)
			HELD_PCT: begin
				if (hv_in[4]) begin
					hn         = HELD_DIGIT;
					tail_digit = in_byte;
				end else begin
					raw[0] = PCT_CHAR;
					n      = 2'd1;
					if (in_byte == PCT_CHAR) begin
						hn = HELD_PCT;
					end else begin
						raw[1] = in_byte;
						n      = 2'd2;
					end
				end
			end
			HELD_DIGIT: begin
				if (hv_in[4]) begin
					raw[0] = {hv_held[3:0], hv_in[3:0]};
					n      = 2'd1;
				end else begin
					raw[0] = PCT_CHAR;
					raw[1] = held_digit;
					n      = 2'd2;
					if (in_byte == PCT_CHAR) begin
						hn = HELD_PCT;
					end else begin
						raw[2] = in_byte;
						n      = 2'd3;
					end
				end
			end
			default: begin
				if (in_byte == PCT_CHAR) begin
					hn = HELD_PCT;
				end else begin
					raw[0] = in_byte;
					n      = 2'd1;
				end
			end
		endcase

		// end of string flushes whatever escape is still open
		if (in_last) begin
			if (hn == HELD_PCT) begin
				raw[n] = PCT_CHAR;
				n      = n + 2'd1;
			end else if (hn == HELD_DIGIT) begin
				raw[0] = PCT_CHAR;
				raw[1] = tail_digit;
				n      = 2'd2;
			end
			hn = HELD_NONE;
		end

		burst.num = n;
		for (int i = 0; i < BURST_MAX; i++) begin
			burst.slot[i].data = (plus_to_space && raw[i] == PLUS_CHAR) ? SPACE_CHAR : raw[i];
			burst.slot[i].last = in_last && (2'(i) == n - 2'd1);
		end
	end

	assign held_next = hn;

endmodule

@@ hdl/pud_out_queue.sv @@
`timescale 1ns / 1ps

module pud_out_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pud_pkg::burst_t burst,
	output logic            room,
	output logic            out_valid,
	input  logic            out_stall,
	output pud_pkg::entry_t head
);
	import pud_pkg::*;

	entry_t           mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [1:0]       push_n;
	logic             pop;

	assign push_n    = push ? burst.num : 2'd0;
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && !out_stall;
	assign head      = mem_q[rd_ptr_q];
	// a full burst must fit even if nothing leaves this cycle
	assign room      = (count_q <= CNT_W'(QUEUE_DEPTH - BURST_MAX));

	always_ff @(posedge clk) begin
		for (int i = 0; i < BURST_MAX; i++) begin
			if (2'(i) < push_n) begin
				mem_q[wr_ptr_q + PTR_W'(i)] <= burst.slot[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("output queue over capacity");

	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |-> room)
		else $error("burst written without room");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && push_n == 2'd0) |=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("queue count lost track of a pop");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q - rd_ptr_q) == PTR_W'(count_q))
		else $error("queue pointers disagree with count");

endmodule

@@ hdl/percent_url_decoder_core.sv @@
`timescale 1ns / 1ps

// Streaming URL percent-escape decoder.
// Input channel: in_valid / in_stall with in_byte, in_last (last char of a string).
// Output channel: out_valid / out_stall with out_byte, out_last.
// An item moves when valid is high and stall is low at a rising edge of clk.
// Config: cfg_valid / cfg_ready write plus_to_space; cfg_ready is always high.
// Write it only while the block is idle.
// Each input item yields zero to three bytes ("%4", "%4x" flushes, end of string).
// They go into a four-entry output queue; when the queue is empty, the first
// byte is on out_byte in the cycle after the input item is accepted.
// Throughput: one input item per cycle while items yield at most one byte and
// out_stall is low; bursts drain at one byte per cycle while out_stall is low,
// and in_stall is high while more than one byte is queued.
// When the receiver stalls, queued bytes hold and in_stall rises once the queue
// cannot take a full burst.
// Reset (arst_n low): no escape held, queue empty, plus_to_space = 1.
module percent_url_decoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       plus_to_space,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_last
);
	import pud_pkg::*;

	logic       p2s_q;
	held_t      held_q;
	held_t      held_next;
	logic [7:0] digit_q;
	burst_t     burst;
	logic       room;
	logic       accept;
	entry_t     head;

	assign cfg_ready = 1'b1;
	assign in_stall  = !room;
	assign accept    = in_valid && room;

	pud_decode u_decode (
		.in_byte       (in_byte),
		.in_last       (in_last),
		.plus_to_space (p2s_q),
		.held          (held_q),
		.held_digit    (digit_q),
		.held_next     (held_next),
		.burst         (burst)
	);

	pud_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.burst     (burst),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign out_byte = head.data;
	assign out_last = head.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p2s_q   <= 1'b1;
			held_q  <= HELD_NONE;
			digit_q <= 8'd0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				p2s_q <= plus_to_space;
			end
			if (accept) begin
				held_q <= held_next;
				if (held_q == HELD_PCT) begin
					digit_q <= in_byte;
				end
			end
		end
	end

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_last) |=> (held_q == HELD_NONE))
		else $error("escape still held after end of string");

	a_held_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && held_next != HELD_NONE && held_q == HELD_NONE) |-> (burst.num == 2'd0))
		else $error("bytes emitted while opening an escape");

	a_no_pct_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q == HELD_DIGIT) |-> (hex_decode(digit_q) != 5'd0))
		else $error("held digit is not hex");

endmodule
